>>> hw/rtl/fdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlp_pkg
// shared types and character codes for the framed decimal list parser
// ----------------------------------------------------------------------------
package fdlp_pkg;

  // frame phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // item kind carried on tuser
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // framing characters
  localparam logic [7:0] CH_START = 8'h73;  // 's'
  localparam logic [7:0] CH_END   = 8'h65;  // 'e'
  localparam logic [7:0] CH_COMMA = 8'h2c;  // ','
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // field widths
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned DCNT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

endpackage

>>> hw/rtl/fdlp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlp_parser
// frame state machine, decimal accumulator and slot / count bookkeeping
// ----------------------------------------------------------------------------
module fdlp_parser import fdlp_pkg::*; #(
  parameter int unsigned MAX_VALUES = 16,
  parameter int unsigned MAX_DIGITS = 15,
  localparam int unsigned AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
  localparam int unsigned SW = $clog2(MAX_VALUES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_en,    // received byte accepted this cycle
  input  logic [7:0]         rx_byte,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [VALUE_W-1:0] wr_data,
  output logic [SW-1:0]      vcnt,       // count before this beat
  output logic [SW-1:0]      vcnt_after, // count after this beat
  output logic               done_after  // done phase after this beat
);

  phase_t               phase_r, phase_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic [DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [SW-1:0]        vcnt_r, vcnt_nxt;

  logic                 is_digit;
  logic                 has_digits;
  logic                 slot_ok;
  logic [VALUE_W-1:0]   acc_x10d;

  assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign has_digits = (dcnt_r != '0);
  assign slot_ok    = (slot_r < SW'(MAX_VALUES));
  // acc * 10 + digit, wrapping at 16 bits
  assign acc_x10d   = {acc_r[VALUE_W-4:0], 3'b000} + {acc_r[VALUE_W-2:0], 1'b0}
                    + VALUE_W'(rx_byte - CH_ZERO);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    slot_nxt  = slot_r;
    vcnt_nxt  = vcnt_r;
    if (byte_en) begin
      unique case (phase_r)
        PH_RECV: begin
          priority if (rx_byte == CH_END) begin
            if (has_digits && slot_ok) begin
              vcnt_nxt = slot_r + SW'(1);
            end
            phase_nxt = PH_DONE;
          end else if (rx_byte == CH_COMMA) begin
            if (has_digits) begin
              if (slot_ok) begin
                slot_nxt = slot_r + SW'(1);
              end
              acc_nxt  = '0;
              dcnt_nxt = '0;
            end
          end else if (is_digit) begin
            if (dcnt_r < DCNT_W'(MAX_DIGITS)) begin
              acc_nxt  = acc_x10d;
              dcnt_nxt = dcnt_r + DCNT_W'(1);
            end else begin
              phase_nxt = PH_IDLE;  // digit overflow
            end
          end else begin
            phase_nxt = PH_IDLE;    // stray character
          end
        end
        PH_DONE: begin
          if (rx_byte == CH_START) begin
            phase_nxt = PH_RECV;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            slot_nxt  = '0;
            vcnt_nxt  = '0;
          end
        end
        default: begin
          // idle and the unused code
          if (rx_byte == CH_START) begin
            phase_nxt = PH_RECV;
            acc_nxt   = '0;
            dcnt_nxt  = '0;
            slot_nxt  = '0;
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    wr_en      = byte_en && (phase_r == PH_RECV) && has_digits && slot_ok &&
                 ((rx_byte == CH_END) || (rx_byte == CH_COMMA));
    wr_addr    = slot_r[AW-1:0];
    wr_data    = acc_r;
    vcnt       = vcnt_r;
    vcnt_after = vcnt_nxt;
    done_after = (phase_nxt == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      dcnt_r  <= '0;
      slot_r  <= '0;
      vcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      slot_r  <= slot_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

endmodule

>>> hw/rtl/fdlp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlp_store
// value slots, one write port and one registered read port
// ----------------------------------------------------------------------------
module fdlp_store import fdlp_pkg::*; #(
  parameter int unsigned MAX_VALUES = 16,
  localparam int unsigned AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [MAX_VALUES];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/framed_decimal_list_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_decimal_list_parser
// stream parser for frames of the form s digits , digits ... e
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one result beat for every input
// beat, in order. A beat with tuser low is a received character: the frame
// state machine steps and decimal fields are stored at consecutive slots as
// 16-bit values (wrapping). A beat with tuser high reads the slot named by
// read_index and returns its value, or zero when the index is not below the
// current count. Every result also carries the done flag and the value count
// as they stand after that beat. From input accept to output valid a beat
// passes the first register stage, which holds the slot read (the store's
// registered read port) and the parser flags, and then the output register.
// Both stages advance together, so with out_tready high a new beat
// is taken every cycle; in_tready drops only when both stages are full and
// the output is stalled. The store needs no clearing after reset, since only
// slots below the count are ever read.
// ----------------------------------------------------------------------------
module framed_decimal_list_parser import fdlp_pkg::*; #(
  parameter int unsigned MAX_VALUES = 16,
  parameter int unsigned MAX_DIGITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] read_index
  input  logic        in_tuser,   // [0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] read_value, [16] packet_done,
                                  // [21:17] value_count, [23:22] zero
);

  localparam int unsigned AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int unsigned SW = $clog2(MAX_VALUES + 1);

  // input beat fields
  logic               kind;
  logic [7:0]         rx_byte;
  logic [7:0]         read_index;
  logic               in_acc;

  // parser / store hookup
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [SW-1:0]      vcnt;
  logic [SW-1:0]      vcnt_after;
  logic               done_after;
  logic               rd_hit;
  logic [VALUE_W-1:0] rd_data;

  // stage one: read in flight plus flags
  logic               s1_v_r, s1_v_nxt;
  logic               s1_hit_r;
  logic               s1_done_r;
  logic [COUNT_W-1:0] s1_cnt_r;
  logic               s1_adv;

  // output register
  logic               out_v_r, out_v_nxt;
  logic [VALUE_W-1:0] out_val_r;
  logic               out_done_r;
  logic [COUNT_W-1:0] out_cnt_r;

  assign kind       = in_tuser;
  assign rx_byte    = in_tdata[7:0];
  assign read_index = in_tdata[15:8];

  // stage one moves on whenever the output register is free or draining
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || !out_v_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // count never exceeds the slot count, so this also bounds the slot index
  assign rd_hit = (kind == KIND_READ) && (read_index < 8'(vcnt));

  fdlp_parser #(
    .MAX_VALUES (MAX_VALUES),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (in_acc && (kind == KIND_BYTE)),
    .rx_byte    (rx_byte),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .vcnt       (vcnt),
    .vcnt_after (vcnt_after),
    .done_after (done_after)
  );

  fdlp_store #(
    .MAX_VALUES (MAX_VALUES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc && rd_hit),
    .rd_addr (read_index[AW-1:0]),
    .rd_data (rd_data)
  );

  // valid flags for both stages
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hit_r  <= rd_hit;
      s1_done_r <= done_after;
      s1_cnt_r  <= COUNT_W'(vcnt_after);
    end
    if (s1_adv) begin
      out_val_r  <= s1_hit_r ? rd_data : '0;
      out_done_r <= s1_done_r;
      out_cnt_r  <= s1_cnt_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_done_r, out_val_r};

endmodule

>>> hw/rtl/fdlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlp_checker
// port-level checks for the framed decimal list parser
// ----------------------------------------------------------------------------
module fdlp_checker import fdlp_pkg::*; #(
  parameter int unsigned MAX_VALUES = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an empty output side never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // count stays within the slot range
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (MAX_VALUES < 32)) |-> (out_tdata[21:17] <= 5'(MAX_VALUES)))
    else $error("value count beyond slot range");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:22] == 2'b00))
    else $error("nonzero pad bits in result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind framed_decimal_list_parser fdlp_checker #(
  .MAX_VALUES (MAX_VALUES)
) u_fdlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
